// File: rtl/assert_macros.svh
// assertion macros shared by the rtl files
// the macros sample on clk_i and are disabled while rst_ni is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge out of reset
`define ASSERT_PROP(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// condition must never be seen at a clock edge out of reset
`define ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error(msg);

`endif

// File: rtl/cpio_pkg.sv
// types, constants and helper functions of the cpio newc stream parser
// no dependencies
`default_nettype none

package cpio_pkg;

  localparam int MaxNameChars = 8;
  localparam int AlignBytes   = 4;
  localparam int EntryBits    = 16;

  localparam int HeaderBytes  = 110;
  localparam int FilesizeAt   = 54;
  localparam int NamesizeAt   = 94;
  localparam int FieldDigits  = 8;
  localparam int TrailerChars = 10;
  localparam int MagicChars   = 6;

  localparam int AlignBits    = $clog2(AlignBytes);

  typedef enum logic [2:0] {
    PhHeader  = 3'd0,
    PhName    = 3'd1,
    PhNamepad = 3'd2,
    PhData    = 3'd3,
    PhDatapad = 3'd4,
    PhEnd     = 3'd5,
    PhError   = 3'd6
  } cpio_phase_e;

  typedef enum logic [0:0] {
    CfgTargetName   = 1'b0,
    CfgTargetLength = 1'b1
  } cpio_cfg_e;

  typedef struct packed {
    cpio_phase_e            phase;
    logic [31:0]            section_count;
    logic [6:0]             header_position;
    logic [31:0]            size;
    logic [31:0]            namesize;
    logic                   hex_stopped;
    logic                   target_equal;
    logic                   trailer_equal;
    logic                   name_done;
    logic [EntryBits-1:0]   entry_count;
    logic [AlignBits-1:0]   align;
  } cpio_state_t;

  localparam cpio_state_t StateReset = '{
    phase:           PhHeader,
    section_count:   '0,
    header_position: '0,
    size:            '0,
    namesize:        '0,
    hex_stopped:     1'b0,
    target_equal:    1'b1,
    trailer_equal:   1'b1,
    name_done:       1'b0,
    entry_count:     '0,
    align:           '0
  };

  typedef struct packed {
    logic [7:0]  byte_value;
    logic [2:0]  byte_role;
    logic [15:0] entry_number;
    logic [31:0] file_length;
    logic [31:0] name_length;
    logic        name_hit;
    logic        archive_end;
    logic        bad_magic;
  } cpio_result_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] digit;
  } cpio_hex_t;

  function automatic logic [7:0] magic_char(input logic [2:0] idx);
    logic [7:0] r;
    case (idx)
      3'd0:    r = "0";
      3'd1:    r = "7";
      3'd2:    r = "0";
      3'd3:    r = "7";
      3'd4:    r = "0";
      3'd5:    r = "1";
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] trailer_char(input logic [3:0] idx);
    logic [7:0] r;
    case (idx)
      4'd0:    r = "T";
      4'd1:    r = "R";
      4'd2:    r = "A";
      4'd3:    r = "I";
      4'd4:    r = "L";
      4'd5:    r = "E";
      4'd6:    r = "R";
      4'd7:    r = "!";
      4'd8:    r = "!";
      4'd9:    r = "!";
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  function automatic cpio_hex_t hex_decode(input logic [7:0] c);
    cpio_hex_t r;
    r = '{ok: 1'b0, digit: 4'd0};
    if (c inside {["0":"9"]}) begin
      r.ok    = 1'b1;
      r.digit = 4'(c - 8'("0"));
    end else if (c inside {["a":"f"]}) begin
      r.ok    = 1'b1;
      r.digit = 4'(c - 8'("a") + 8'd10);
    end else if (c inside {["A":"F"]}) begin
      r.ok    = 1'b1;
      r.digit = 4'(c - 8'("A") + 8'd10);
    end
    return r;
  endfunction

  // skips finished or empty sections and zero-length pads
  function automatic cpio_state_t settle(input cpio_state_t s);
    cpio_state_t r;
    r = s;
    if (r.phase == PhName && r.section_count >= r.namesize) r.phase = PhNamepad;
    if (r.phase == PhNamepad && r.align == '0) begin
      r.phase         = PhData;
      r.section_count = '0;
    end
    if (r.phase == PhData && r.section_count >= r.size) r.phase = PhDatapad;
    if (r.phase == PhDatapad && r.align == '0) begin
      r.phase           = PhHeader;
      r.header_position = '0;
      if (r.entry_count != '1) r.entry_count = r.entry_count + 1'b1;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// File: rtl/cpio_if.sv
// valid/ready channel interfaces of the cpio newc stream parser
// no dependencies
`default_nettype none

interface cpio_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] archive_byte;

  modport source (output valid, output archive_byte, input ready);
  modport sink (input valid, input archive_byte, output ready);
endinterface

interface cpio_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  byte_value;
  logic [2:0]  byte_role;
  logic [15:0] entry_number;
  logic [31:0] file_length;
  logic [31:0] name_length;
  logic        name_hit;
  logic        archive_end;
  logic        bad_magic;

  modport source (output valid, output byte_value, output byte_role, output entry_number,
                  output file_length, output name_length, output name_hit,
                  output archive_end, output bad_magic, input ready);
  modport sink (input valid, input byte_value, input byte_role, input entry_number,
                input file_length, input name_length, input name_hit,
                input archive_end, input bad_magic, output ready);
endinterface

`default_nettype wire

// File: rtl/cpio_step.sv
// next-state and result logic for one archive byte
// depends on cpio_pkg
`default_nettype none

module cpio_step (
  input  cpio_pkg::cpio_state_t  state_i,
  input  logic [7:0]             byte_i,
  input  logic [63:0]            target_name_i,
  input  logic [3:0]             target_length_i,
  output cpio_pkg::cpio_state_t  state_o,
  output cpio_pkg::cpio_result_t result_o
);
  import cpio_pkg::*;

  cpio_state_t nx;
  cpio_phase_e role;
  cpio_hex_t   hv;
  logic [6:0]  pos;
  logic [31:0] idx;
  logic [3:0]  len;

  assign pos = state_i.header_position;
  assign idx = state_i.section_count;
  assign hv  = hex_decode(byte_i);
  assign len = (target_length_i > 4'(MaxNameChars)) ? 4'(MaxNameChars) : target_length_i;

  always_comb begin
    nx   = state_i;
    role = state_i.phase;
    case (state_i.phase)
      PhHeader: begin
        if (pos == '0) begin
          nx.size          = '0;
          nx.namesize      = '0;
          nx.target_equal  = 1'b1;
          nx.trailer_equal = 1'b1;
          nx.name_done     = 1'b0;
        end
        if (pos < 7'(MagicChars) && byte_i != magic_char(pos[2:0])) begin
          nx.phase = PhError;
          role     = PhError;
        end else begin
          if (pos == 7'(FilesizeAt) || pos == 7'(NamesizeAt)) nx.hex_stopped = 1'b0;
          if (pos >= 7'(FilesizeAt) && pos < 7'(FilesizeAt + FieldDigits)) begin
            if (!nx.hex_stopped) begin
              if (hv.ok) nx.size = {nx.size[27:0], hv.digit};
              else nx.hex_stopped = 1'b1;
            end
          end else if (pos >= 7'(NamesizeAt) && pos < 7'(NamesizeAt + FieldDigits)) begin
            if (!nx.hex_stopped) begin
              if (hv.ok) nx.namesize = {nx.namesize[27:0], hv.digit};
              else nx.hex_stopped = 1'b1;
            end
          end
          nx.align = state_i.align + 1'b1;
          if (pos == 7'(HeaderBytes - 1)) begin
            nx.header_position = '0;
            nx.section_count   = '0;
            nx.phase           = PhName;
            nx                 = settle(nx);
          end else begin
            nx.header_position = pos + 7'd1;
          end
        end
      end
      PhName: begin
        if (!state_i.name_done) begin
          if (idx < 32'(len)) begin
            if (byte_i != target_name_i[{idx[2:0], 3'b000} +: 8]) nx.target_equal = 1'b0;
          end else if (idx == 32'(len)) begin
            if (byte_i != 8'h00) nx.target_equal = 1'b0;
          end else begin
            nx.target_equal = 1'b0;
          end
          if (idx < 32'(TrailerChars)) begin
            if (byte_i != trailer_char(idx[3:0])) nx.trailer_equal = 1'b0;
          end else if (idx == 32'(TrailerChars)) begin
            if (byte_i != 8'h00) nx.trailer_equal = 1'b0;
          end else begin
            nx.trailer_equal = 1'b0;
          end
          if (byte_i == 8'h00) nx.name_done = 1'b1;
        end
        nx.section_count = state_i.section_count + 32'd1;
        nx.align         = state_i.align + 1'b1;
        if (nx.name_done && nx.trailer_equal) nx.phase = PhEnd;
        else nx = settle(nx);
      end
      PhNamepad, PhDatapad: begin
        nx.align = state_i.align + 1'b1;
        nx       = settle(nx);
      end
      PhData: begin
        nx.section_count = state_i.section_count + 32'd1;
        nx.align         = state_i.align + 1'b1;
        nx               = settle(nx);
      end
      default: begin
        nx = state_i;
      end
    endcase
  end

  assign state_o = nx;

  always_comb begin
    result_o.byte_value   = byte_i;
    result_o.byte_role    = role;
    result_o.entry_number = 16'(state_i.entry_count);
    result_o.file_length  = nx.size;
    result_o.name_length  = nx.namesize;
    result_o.name_hit     = nx.phase != PhEnd && nx.phase != PhError && nx.name_done &&
                            nx.target_equal && !nx.trailer_equal;
    result_o.archive_end  = nx.phase == PhEnd;
    result_o.bad_magic    = nx.phase == PhError;
  end

endmodule

`default_nettype wire

// File: rtl/cpio_newc_stream_parser_core.sv
// channel      | dir | payload                                   | handshake
// in_if        | in  | archive_byte                              | valid/ready
// out_if       | out | byte_value, byte_role, entry_number, ...   | valid/ready
// cfg_*        | in  | target_name (0), target_length (1)        | write enable
// one byte per cycle unless out_if stalls; a result is registered and offered in the cycle after its byte is taken
// the parser state and the result register update together on each transaction
// in_if.ready stays high while the result register is empty or being drained
// reset puts the parser in the header phase with both size registers cleared
// depends on cpio_pkg, cpio_if, cpio_step and assert_macros.svh
`default_nettype none

module cpio_newc_stream_parser_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  cpio_in_if.sink     in_if,
  cpio_out_if.source  out_if,
  input  logic        cfg_we_i,
  input  logic [0:0]  cfg_index_i,
  input  logic [63:0] cfg_wdata_i
);
  import cpio_pkg::*;
  `include "assert_macros.svh"

  cpio_state_t  state_q, state_d;
  cpio_result_t res_q, res_d;
  logic         out_valid_q;
  logic [63:0]  target_name_q;
  logic [3:0]   target_length_q;
  logic         in_fire;

  assign in_if.ready = !out_valid_q || out_if.ready;
  assign in_fire     = in_if.valid && in_if.ready;

  cpio_step u_step (
    .state_i         (state_q),
    .byte_i          (in_if.archive_byte),
    .target_name_i   (target_name_q),
    .target_length_i (target_length_q),
    .state_o         (state_d),
    .result_o        (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_name_q   <= '0;
      target_length_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CfgTargetName:   target_name_q   <= cfg_wdata_i;
        CfgTargetLength: target_length_q <= cfg_wdata_i[3:0];
        default:         target_name_q   <= target_name_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StateReset;
      out_valid_q <= 1'b0;
    end else begin
      if (in_fire) state_q <= state_d;
      if (in_fire) out_valid_q <= 1'b1;
      else if (out_if.ready) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) res_q <= res_d;
  end

  assign out_if.valid        = out_valid_q;
  assign out_if.byte_value   = res_q.byte_value;
  assign out_if.byte_role    = res_q.byte_role;
  assign out_if.entry_number = res_q.entry_number;
  assign out_if.file_length  = res_q.file_length;
  assign out_if.name_length  = res_q.name_length;
  assign out_if.name_hit     = res_q.name_hit;
  assign out_if.archive_end  = res_q.archive_end;
  assign out_if.bad_magic    = res_q.bad_magic;

  `ASSERT_PROP(a_error_sticky, state_q.phase == PhError |=> state_q.phase == PhError, "error left")
  `ASSERT_PROP(a_end_sticky, state_q.phase == PhEnd |=> state_q.phase == PhEnd, "end left")
  `ASSERT_PROP(a_entry_mono, state_q.entry_count >= $past(state_q.entry_count), "entry dropped")
  `ASSERT_NEVER(a_hdr_pos, state_q.header_position >= 7'(HeaderBytes), "header position overrun")
  `ASSERT_PROP(a_ready_empty, !out_valid_q |-> in_if.ready, "stall with empty result register")
  `ASSERT_NEVER(a_hit_error, out_valid_q && res_q.bad_magic && res_q.name_hit, "hit after error")

endmodule

`default_nettype wire

// File: tb/tb_cpio_newc_stream_parser_core.sv
// self-checking testbench of cpio_newc_stream_parser_core: builds newc archives byte by byte,
// predicts the tag and fields of every byte and compares them with the result channel
// depends on cpio_pkg, cpio_if and cpio_newc_stream_parser_core from the rtl folder

import cpio_pkg::*;

typedef logic [7:0] name_t[$];

class newc_byte_tracker;
  cpio_result_t                predicted[$];
  int unsigned                 errors;
  logic [63:0]                 target_name;
  logic [3:0]                  target_len;
  cpio_phase_e                 phase;
  logic [31:0]                 section_count;
  logic [31:0]                 size_reg;
  logic [31:0]                 namesize_reg;
  logic [6:0]                  header_pos;
  bit                          hex_stopped;
  bit                          target_equal;
  bit                          trailer_equal;
  bit                          name_done;
  logic [EntryBits-1:0]        entry_count;
  logic [AlignBits-1:0]        align;

  function new();
    errors        = 0;
    target_name   = '0;
    target_len    = '0;
    phase         = PhHeader;
    section_count = '0;
    size_reg      = '0;
    namesize_reg  = '0;
    header_pos    = '0;
    hex_stopped   = 1'b0;
    target_equal  = 1'b1;
    trailer_equal = 1'b1;
    name_done     = 1'b0;
    entry_count   = '0;
    align         = '0;
  endfunction

  function void set_reg(input cpio_cfg_e idx, input logic [63:0] value);
    if (idx == CfgTargetName) begin
      target_name = value;
    end else begin
      target_len = value[3:0];
    end
  endfunction

  function logic [7:0] magic_char(input int p);
    logic [47:0] text;
    text = "070701";
    return text[8 * (MagicChars - 1 - p) +: 8];
  endfunction

  function logic [7:0] trailer_char(input int i);
    logic [79:0] text;
    text = "TRAILER!!!";
    return text[8 * (TrailerChars - 1 - i) +: 8];
  endfunction

  function bit hex_nibble(input logic [7:0] c, output logic [3:0] d);
    d = 4'd0;
    if (c >= "0" && c <= "9") begin
      d = 4'(c - "0");
      return 1'b1;
    end
    if (c >= "a" && c <= "f") begin
      d = 4'(c - "a" + 8'd10);
      return 1'b1;
    end
    if (c >= "A" && c <= "F") begin
      d = 4'(c - "A" + 8'd10);
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function void shift_digit(inout logic [31:0] field, input logic [7:0] c);
    logic [3:0] d;
    if (hex_stopped) return;
    if (hex_nibble(c, d)) begin
      field = (field << 4) + 32'(d);
    end else begin
      hex_stopped = 1'b1;
    end
  endfunction

  // empty sections and zero-length pads fall through here
  function void skip_sections();
    if (phase == PhName && section_count >= namesize_reg) phase = PhNamepad;
    if (phase == PhNamepad && align == '0) begin
      phase         = PhData;
      section_count = '0;
    end
    if (phase == PhData && section_count >= size_reg) phase = PhDatapad;
    if (phase == PhDatapad && align == '0) begin
      phase      = PhHeader;
      header_pos = '0;
      if (entry_count != '1) entry_count = entry_count + 1'b1;
    end
  endfunction

  function void compare_char(input logic [7:0] c);
    int unsigned lim;
    int unsigned i;
    lim = (target_len > MaxNameChars) ? MaxNameChars : target_len;
    i   = section_count;
    if (i < lim) begin
      if (c != target_name[8 * i +: 8]) target_equal = 1'b0;
    end else if (i == lim) begin
      if (c != 8'h00) target_equal = 1'b0;
    end else begin
      target_equal = 1'b0;
    end
    if (i < TrailerChars) begin
      if (c != trailer_char(i)) trailer_equal = 1'b0;
    end else if (i == TrailerChars) begin
      if (c != 8'h00) trailer_equal = 1'b0;
    end else begin
      trailer_equal = 1'b0;
    end
    if (c == 8'h00) name_done = 1'b1;
  endfunction

  function void take_byte(input logic [7:0] c);
    cpio_phase_e          role;
    logic [EntryBits-1:0] shown;
    int unsigned          p;
    cpio_result_t         r;
    role  = phase;
    shown = entry_count;
    case (phase)
      PhHeader: begin
        p = header_pos;
        if (p == 0) begin
          size_reg      = '0;
          namesize_reg  = '0;
          target_equal  = 1'b1;
          trailer_equal = 1'b1;
          name_done     = 1'b0;
        end
        if (p < MagicChars && c != magic_char(p)) begin
          phase = PhError;
          role  = PhError;
        end else begin
          if (p == FilesizeAt || p == NamesizeAt) hex_stopped = 1'b0;
          if (p >= FilesizeAt && p < FilesizeAt + FieldDigits) begin
            shift_digit(size_reg, c);
          end else if (p >= NamesizeAt && p < NamesizeAt + FieldDigits) begin
            shift_digit(namesize_reg, c);
          end
          align = align + 1'b1;
          if (p + 1 >= HeaderBytes) begin
            header_pos    = '0;
            section_count = '0;
            phase         = PhName;
            skip_sections();
          end else begin
            header_pos = 7'(p + 1);
          end
        end
      end
      PhName: begin
        if (!name_done) compare_char(c);
        section_count = section_count + 1;
        align         = align + 1'b1;
        if (name_done && trailer_equal) begin
          phase = PhEnd;
        end else begin
          skip_sections();
        end
      end
      PhNamepad, PhDatapad: begin
        align = align + 1'b1;
        skip_sections();
      end
      PhData: begin
        section_count = section_count + 1;
        align         = align + 1'b1;
        skip_sections();
      end
      default: begin
      end
    endcase
    r.byte_value   = c;
    r.byte_role    = role;
    r.entry_number = 16'(shown);
    r.file_length  = size_reg;
    r.name_length  = namesize_reg;
    r.name_hit     = phase != PhEnd && phase != PhError && name_done && target_equal &&
                     !trailer_equal;
    r.archive_end  = phase == PhEnd;
    r.bad_magic    = phase == PhError;
    predicted.push_back(r);
  endfunction

  function void check_field(input string fname, input logic [31:0] want,
                            input logic [31:0] seen);
    if (want !== seen) begin
      errors++;
      $display("%0t: %s expected %0h actual %0h", $time, fname, want, seen);
    end
  endfunction

  function void match_result(input cpio_result_t seen);
    cpio_result_t want;
    if (predicted.size() == 0) begin
      errors++;
      $display("%0t: unexpected transaction, expected none actual byte %0h", $time,
               seen.byte_value);
      return;
    end
    want = predicted.pop_front();
    check_field("byte_value", 32'(want.byte_value), 32'(seen.byte_value));
    check_field("byte_role", 32'(want.byte_role), 32'(seen.byte_role));
    check_field("entry_number", 32'(want.entry_number), 32'(seen.entry_number));
    check_field("file_length", want.file_length, seen.file_length);
    check_field("name_length", want.name_length, seen.name_length);
    check_field("name_hit", 32'(want.name_hit), 32'(seen.name_hit));
    check_field("archive_end", 32'(want.archive_end), 32'(seen.archive_end));
    check_field("bad_magic", 32'(want.bad_magic), 32'(seen.bad_magic));
  endfunction
endclass

module tb_cpio_newc_stream_parser_core;
  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [0:0]  cfg_index_i;
  logic [63:0] cfg_wdata_i;

  cpio_in_if  in_ch ();
  cpio_out_if out_ch ();

  newc_byte_tracker tracker;
  logic [7:0]       archive_q[$];
  int               bytes_sent;
  logic             burst_mode;
  logic             sink_hold;

  cpio_newc_stream_parser_core DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_if       (in_ch),
    .out_if      (out_ch),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #2000000;
    $display("TB_ERROR");
    $finish;
  end

  function automatic int idle_cycles();
    if (burst_mode) return 0;
    return $urandom_range(0, 10);
  endfunction

  function automatic logic [7:0] rand_byte();
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic logic [7:0] hex_text(input logic [3:0] d);
    if (d < 4'd10) return "0" + 8'(d);
    return ($urandom_range(0, 1) ? "A" : "a") + 8'(d) - 8'd10;
  endfunction

  // leading digits of a size field, then a non-hex stop and filler
  function automatic logic [7:0] field_char(input logic [31:0] value, input int stop,
                                            input int j);
    int         k;
    logic [7:0] c;
    logic [3:0] d;
    k = (stop > FieldDigits) ? FieldDigits : stop;
    if (j < k) return hex_text(4'(value >> (4 * (k - 1 - j))));
    if (j == k) begin
      do c = rand_byte(); while (tracker.hex_nibble(c, d));
      return c;
    end
    return rand_byte();
  endfunction

  function automatic name_t text_bytes(input string s);
    name_t q;
    for (int i = 0; i < s.len(); i++) q.push_back(s[i]);
    return q;
  endfunction

  function automatic name_t target_bytes();
    name_t q;
    int    lim;
    lim = (tracker.target_len > MaxNameChars) ? MaxNameChars : tracker.target_len;
    for (int i = 0; i < lim; i++) q.push_back(tracker.target_name[8 * i +: 8]);
    return q;
  endfunction

  task automatic add_header(input logic [31:0] fsize, input logic [31:0] nsize,
                            input int fstop, input int nstop);
    for (int p = 0; p < HeaderBytes; p++) begin
      if (p < MagicChars) begin
        archive_q.push_back(tracker.magic_char(p));
      end else if (p >= FilesizeAt && p < FilesizeAt + FieldDigits) begin
        archive_q.push_back(field_char(fsize, fstop, p - FilesizeAt));
      end else if (p >= NamesizeAt && p < NamesizeAt + FieldDigits) begin
        archive_q.push_back(field_char(nsize, nstop, p - NamesizeAt));
      end else if ($urandom_range(0, 7) != 0) begin
        archive_q.push_back(hex_text(4'($urandom_range(0, 15))));
      end else begin
        archive_q.push_back(rand_byte());
      end
    end
  endtask

  // sizes are the values the parser will see after any stop character
  task automatic add_entry(input logic [31:0] fsize, input logic [31:0] nsize,
                           input int fstop, input int nstop, input name_t nm,
                           input bit term);
    int pad;
    add_header(fsize, nsize, fstop, nstop);
    for (int i = 0; i < nsize; i++) begin
      if (i < nm.size()) begin
        archive_q.push_back(nm[i]);
      end else if (i == nm.size() && term) begin
        archive_q.push_back(8'h00);
      end else if (term) begin
        archive_q.push_back(rand_byte());
      end else begin
        archive_q.push_back(8'($urandom_range(1, 255)));
      end
    end
    pad = (AlignBytes - (HeaderBytes + nsize) % AlignBytes) % AlignBytes;
    repeat (pad) archive_q.push_back(rand_byte());
    repeat (fsize) archive_q.push_back(rand_byte());
    repeat ((AlignBytes - fsize % AlignBytes) % AlignBytes) archive_q.push_back(rand_byte());
  endtask

  task automatic add_random_entry();
    name_t       nm;
    bit          term;
    int          pick;
    int          fstop;
    int          nstop;
    logic [31:0] fsize;
    logic [31:0] nsize;
    pick = $urandom_range(0, 9);
    if (pick < 4) begin
      nm = target_bytes();
    end else if (pick < 6) begin
      nm = target_bytes();
      if (nm.size() > 0 && $urandom_range(0, 1)) begin
        void'(nm.pop_back());
      end else begin
        nm.push_back(8'($urandom_range(1, 255)));
      end
    end else begin
      repeat ($urandom_range(0, 10)) nm.push_back(8'($urandom_range(1, 255)));
    end
    term  = $urandom_range(0, 7) != 0;
    nsize = nm.size() + (term ? 1 + $urandom_range(0, 3) : 0);
    if ($urandom_range(0, 15) == 0) nsize = 0;
    fsize = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 24);
    fstop = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 7) : FieldDigits;
    nstop = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 7) : FieldDigits;
    if (fstop < FieldDigits) fsize = fsize & ((32'd1 << (4 * fstop)) - 1);
    if (nstop < FieldDigits) nsize = nsize & ((32'd1 << (4 * nstop)) - 1);
    add_entry(fsize, nsize, fstop, nstop, nm, term);
  endtask

  task automatic add_trailer();
    name_t nm;
    if ($urandom_range(0, 1)) begin
      add_header('1, '1, FieldDigits, FieldDigits);
    end else begin
      add_header($urandom_range(0, 40), $urandom_range(11, 20), FieldDigits, FieldDigits);
    end
    nm = text_bytes("TRAILER!!!");
    foreach (nm[i]) archive_q.push_back(nm[i]);
    archive_q.push_back(8'h00);
    repeat (16) archive_q.push_back(rand_byte());
  endtask

  task automatic add_bad_magic();
    int         p;
    logic [7:0] c;
    p = $urandom_range(0, MagicChars - 1);
    for (int i = 0; i < p; i++) archive_q.push_back(tracker.magic_char(i));
    do c = rand_byte(); while (c == tracker.magic_char(p));
    archive_q.push_back(c);
    repeat (16) archive_q.push_back(rand_byte());
  endtask

  task automatic write_reg(input cpio_cfg_e idx, input logic [63:0] value);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    tracker.set_reg(idx, value);
  endtask

  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = sink_hold ? 0 : idle_cycles();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_ch.valid        <= 1'b1;
    in_ch.archive_byte <= b;
    do @(posedge clk_i); while (!in_ch.ready);
    tracker.take_byte(b);
    bytes_sent++;
  endtask

  task automatic flush_archive();
    while (archive_q.size() != 0) send_byte(archive_q.pop_front());
    in_ch.valid <= 1'b0;
    while (tracker.predicted.size() != 0) @(posedge clk_i);
  endtask

  initial begin
    burst_mode <= 1'b0;
    forever begin
      repeat ($urandom_range(50, 300)) @(posedge clk_i);
      burst_mode <= ~burst_mode;
    end
  end

  // long receiver hold-off while the sender keeps offering bytes
  initial begin
    sink_hold <= 1'b0;
    wait (bytes_sent >= 300);
    @(posedge clk_i);
    sink_hold <= 1'b1;
    repeat (400) @(posedge clk_i);
    sink_hold <= 1'b0;
  end

  initial begin
    int           stall;
    cpio_result_t seen;
    out_ch.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      stall = idle_cycles();
      if (stall > 0 || sink_hold) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
        while (sink_hold) @(posedge clk_i);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk_i); while (!out_ch.valid);
      seen = '{out_ch.byte_value, out_ch.byte_role, out_ch.entry_number, out_ch.file_length,
               out_ch.name_length, out_ch.name_hit, out_ch.archive_end, out_ch.bad_magic};
      tracker.match_result(seen);
    end
  end

  initial begin
    int    random_bytes;
    tracker            = new();
    bytes_sent         = 0;
    rst_ni             <= 1'b0;
    in_ch.valid        <= 1'b0;
    in_ch.archive_byte <= 8'h00;
    cfg_we_i           <= 1'b0;
    cfg_index_i        <= CfgTargetName;
    cfg_wdata_i        <= '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset target: empty name matches
    add_entry(0, 1, FieldDigits, FieldDigits, text_bytes(""), 1'b1);
    add_entry(5, 6, 3, FieldDigits, text_bytes("ab"), 1'b1);
    add_entry(7, 0, FieldDigits, 0, text_bytes("zz"), 1'b1);
    add_entry(1, 12, FieldDigits, FieldDigits, text_bytes("TRAILER!!!X"), 1'b1);
    flush_archive();

    random_bytes = 0;
    while (random_bytes < 100) begin
      write_reg(CfgTargetName, {$urandom, $urandom});
      write_reg(CfgTargetLength, 64'($urandom_range(0, 15)));
      add_random_entry();
      random_bytes += archive_q.size();
      flush_archive();
    end

    if ($urandom_range(0, 1)) begin
      add_trailer();
    end else begin
      add_bad_magic();
    end
    flush_archive();

    repeat (8) @(posedge clk_i);
    if (tracker.errors == 0 && tracker.predicted.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule
